// File: rtl/core/sfl_pkg.sv
// Shared constants and helpers for the switch frame line parser.
// Holds character codes, the frame prefix and parameter defaults.
// No dependencies.
`default_nettype none

package sfl_pkg;

  localparam int LINE_MAX_DEFAULT   = 32;
  localparam int CELL_COUNT_DEFAULT = 12;
  localparam int PREFIX_LEN         = 3;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_RETURN  = 8'h0D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_ONE     = 8'h31;
  localparam logic [7:0] CHAR_S       = 8'h53;
  localparam logic [7:0] CHAR_W       = 8'h57;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;

  typedef logic [7:0] char_t;

  function automatic char_t prefix_char(input logic [1:0] idx);
    char_t ch;
    ch = CHAR_COLON;
    unique case (idx)
      2'd0:    ch = CHAR_S;
      2'd1:    ch = CHAR_W;
      default: ch = CHAR_COLON;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/switch_frame_line_parser.sv
// Switch frame line parser: checks "SW:" frames byte by byte, one result per byte.
// Depends on sfl_pkg for character codes and defaults.
//
// Usage: bytes arrive on rx_byte with in_valid/in_stall; one result per byte
// leaves on out_valid/out_stall carrying the latest switch state and the
// event pulses for that byte. A byte transfers when valid is high and stall
// is low. A byte's result is computed combinationally and registered in the
// output register, or in the skid register while the output is held.
// Throughput is one byte per cycle while in_stall is low; the line checks
// are incremental, so a byte's work fits between the input transfer and the result register.
// When the receiver stalls, the current result holds and a second result
// is kept in a one-entry skid register; in_stall rises only while that skid
// entry is full, so the input side sees stall once a byte has arrived behind a held output.
// Reset (rst, synchronous) empties both result registers, starts an empty
// line and clears the stored switch state and its valid flag.
`default_nettype none

module switch_frame_line_parser #(
  parameter int LINE_MAX   = sfl_pkg::LINE_MAX_DEFAULT,
  parameter int CELL_COUNT = sfl_pkg::CELL_COUNT_DEFAULT
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [7:0]            rx_byte,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [CELL_COUNT-1:0] switch_state,
  output logic                  state_valid,
  output logic                  frame_accepted,
  output logic                  state_changed,
  output logic                  frame_error,
  output logic                  line_overflow
);

  import sfl_pkg::*;

  localparam int LenW     = $clog2(LINE_MAX);
  localparam int FrameLen = PREFIX_LEN + CELL_COUNT;
  localparam int ResW     = CELL_COUNT + 5;
  localparam logic [LenW-1:0] LenLast = LenW'(LINE_MAX - 1);

  logic [LenW-1:0]       line_length, line_length_next;
  logic                  prefix_good, prefix_good_next;
  logic                  digits_good, digits_good_next;
  logic [CELL_COUNT-1:0] bit_accumulator, bit_accumulator_next;
  logic [CELL_COUNT-1:0] switch_bits, switch_bits_next;
  logic                  have_valid, have_valid_next;

  logic                  ev_accepted, ev_changed, ev_error, ev_overflow;
  logic [LenW-1:0]       digit_pos;
  logic [ResW-1:0]       result;
  logic [ResW-1:0]       out_data, skid_data;
  logic                  skid_valid;
  logic                  in_take, out_take;

  assign in_stall = skid_valid;
  assign in_take  = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;
  assign digit_pos = line_length - LenW'(PREFIX_LEN);

  always_comb begin
    line_length_next     = line_length;
    prefix_good_next     = prefix_good;
    digits_good_next     = digits_good;
    bit_accumulator_next = bit_accumulator;
    switch_bits_next     = switch_bits;
    have_valid_next      = have_valid;
    ev_accepted          = 1'b0;
    ev_changed           = 1'b0;
    ev_error             = 1'b0;
    ev_overflow          = 1'b0;
    if (rx_byte == CHAR_NEWLINE) begin
      if (prefix_good && digits_good && (32'(line_length) >= 32'(FrameLen))) begin
        ev_accepted      = 1'b1;
        ev_changed       = !have_valid || (bit_accumulator != switch_bits);
        switch_bits_next = bit_accumulator;
        have_valid_next  = 1'b1;
      end else if (line_length != '0) begin
        ev_error = 1'b1;
      end
      line_length_next     = '0;
      prefix_good_next     = 1'b1;
      digits_good_next     = 1'b1;
      bit_accumulator_next = '0;
    end else if (rx_byte != CHAR_RETURN) begin
      if (line_length < LenLast) begin
        if (32'(line_length) < 32'(PREFIX_LEN)) begin
          if (rx_byte != prefix_char(line_length[1:0])) begin
            prefix_good_next = 1'b0;
          end
        end else if (32'(line_length) < 32'(FrameLen)) begin
          if (rx_byte == CHAR_ONE) begin
            bit_accumulator_next = bit_accumulator | (CELL_COUNT'(1) << digit_pos);
          end else if (rx_byte != CHAR_ZERO) begin
            digits_good_next = 1'b0;
          end
        end
        line_length_next = line_length + LenW'(1);
      end else begin
        ev_overflow          = 1'b1;
        line_length_next     = '0;
        prefix_good_next     = 1'b1;
        digits_good_next     = 1'b1;
        bit_accumulator_next = '0;
      end
    end
  end

  assign result = {switch_bits_next, have_valid_next, ev_accepted, ev_changed,
                   ev_error, ev_overflow};

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= '0;
      prefix_good     <= 1'b1;
      digits_good     <= 1'b1;
      bit_accumulator <= '0;
      switch_bits     <= '0;
      have_valid      <= 1'b0;
    end else if (in_take) begin
      line_length     <= line_length_next;
      prefix_good     <= prefix_good_next;
      digits_good     <= digits_good_next;
      bit_accumulator <= bit_accumulator_next;
      switch_bits     <= switch_bits_next;
      have_valid      <= have_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= result;
        out_valid <= in_take;
      end
    end else if (in_take) begin
      skid_data  <= result;
      skid_valid <= 1'b1;
    end
  end

  assign switch_state   = out_data[ResW-1:5];
  assign state_valid    = out_data[4];
  assign frame_accepted = out_data[3];
  assign state_changed  = out_data[2];
  assign frame_error    = out_data[1];
  assign line_overflow  = out_data[0];

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a presented result");

  a_changed_needs_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && state_changed |-> frame_accepted)
    else $error("state change without accepted frame");

  a_events_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({frame_accepted, frame_error, line_overflow}) <= 1)
    else $error("more than one line event on one result");

  a_accept_sets_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_accepted |-> state_valid)
    else $error("accepted frame without valid state");

endmodule

`default_nettype wire

// File: dv/switch_frame_line_parser_tb.sv
// Testbench for switch_frame_line_parser: drives bytes through the valid/stall input,
// predicts each per-byte result and checks it field by field on the output side.
// Depends on sfl_pkg and the switch_frame_line_parser RTL.
`timescale 1ns / 1ps

module testbench;
  import sfl_pkg::*;

  localparam int CELLS       = CELL_COUNT_DEFAULT;
  localparam int LINE_LIMIT  = LINE_MAX_DEFAULT;
  localparam int FRAME_CHARS = PREFIX_LEN + CELLS;
  localparam int IDLE_LIMIT  = 500;

  typedef struct packed {
    logic [CELLS-1:0] state;
    logic             valid;
    logic             accepted;
    logic             changed;
    logic             ferr;
    logic             ovf;
  } byte_result_t;

  typedef enum int {FREE_RUN, LIGHT, HEAVY, PERIODIC} stall_mode_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  char_t            rx_byte;
  logic             out_valid;
  logic             out_stall;
  logic [CELLS-1:0] switch_state;
  logic             state_valid;
  logic             frame_accepted;
  logic             state_changed;
  logic             frame_error;
  logic             line_overflow;

  switch_frame_line_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .switch_state  (switch_state),
    .state_valid   (state_valid),
    .frame_accepted(frame_accepted),
    .state_changed (state_changed),
    .frame_error   (frame_error),
    .line_overflow (line_overflow)
  );

  // parser shadow state
  int               shadow_len;
  logic             prefix_ok;
  logic             digits_ok;
  logic [CELLS-1:0] line_bits;
  logic [CELLS-1:0] stored_bits;
  logic             have_valid;

  byte_result_t     pending_results[$];
  logic [CELLS-1:0] last_sent_bits;
  logic             sender_on;
  int               burst_left;
  int               bytes_sent;
  int               mismatches;
  int               frames_seen;
  int               changes_seen;
  int               errors_seen;
  int               overflows_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void restart_line();
    shadow_len = 0;
    prefix_ok  = 1'b1;
    digits_ok  = 1'b1;
    line_bits  = '0;
  endfunction

  function automatic byte_result_t parse_byte(input char_t c);
    byte_result_t r;
    char_t        tag;
    r = '0;
    if (c == CHAR_NEWLINE) begin
      if (prefix_ok && digits_ok && shadow_len >= FRAME_CHARS) begin
        r.accepted  = 1'b1;
        r.changed   = !have_valid || (line_bits != stored_bits);
        stored_bits = line_bits;
        have_valid  = 1'b1;
      end else if (shadow_len > 0) begin
        r.ferr = 1'b1;
      end
      restart_line();
    end else if (c != CHAR_RETURN) begin
      if (shadow_len < LINE_LIMIT - 1) begin
        if (shadow_len < PREFIX_LEN) begin
          case (shadow_len)
            0:       tag = CHAR_S;
            1:       tag = CHAR_W;
            default: tag = CHAR_COLON;
          endcase
          if (c != tag) prefix_ok = 1'b0;
        end else if (shadow_len < FRAME_CHARS) begin
          if (c == CHAR_ONE) line_bits[shadow_len - PREFIX_LEN] = 1'b1;
          else if (c != CHAR_ZERO) digits_ok = 1'b0;
        end
        shadow_len++;
      end else begin
        r.ovf = 1'b1;
        restart_line();
      end
    end
    r.state = stored_bits;
    r.valid = have_valid;
    return r;
  endfunction

  function automatic char_t noise_byte();
    char_t b;
    do b = char_t'($urandom_range(0, 255)); while (b == CHAR_NEWLINE);
    return b;
  endfunction

  // hold the byte until the transfer, then record its result and pace the burst
  task automatic send_byte(input char_t b);
    int gap;
    in_valid  <= 1'b1;
    sender_on  = 1'b1;
    rx_byte   <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(parse_byte(b));
    bytes_sent++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
      gap        = $urandom_range(1, 6);
      in_valid  <= 1'b0;
      sender_on  = 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // keep: frame characters sent; bad_at: position to corrupt (-1 for none)
  task automatic send_frame(input logic [CELLS-1:0] bits, input int keep, input int bad_at,
                            input int extra);
    char_t c;
    for (int i = 0; i < keep; i++) begin
      if (i == 0)                c = CHAR_S;
      else if (i == 1)           c = CHAR_W;
      else if (i == PREFIX_LEN - 1) c = CHAR_COLON;
      else                       c = bits[i - PREFIX_LEN] ? CHAR_ONE : CHAR_ZERO;
      if (i == bad_at) c = noise_byte();
      if ($urandom_range(0, 15) == 0) send_byte(CHAR_RETURN);
      send_byte(c);
    end
    repeat (extra) send_byte(noise_byte());
    if ($urandom_range(0, 2) == 0) send_byte(CHAR_RETURN);
    send_byte(CHAR_NEWLINE);
    last_sent_bits = bits;
  endtask

  task automatic test_blank_lines();
    send_byte(CHAR_RETURN);
    send_byte(CHAR_NEWLINE);
    send_byte(CHAR_RETURN);
    send_byte(CHAR_NEWLINE);
  endtask

  task automatic test_first_frame();
    send_frame(12'h5A3, FRAME_CHARS, -1, 0);
  endtask

  task automatic test_bad_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_NEWLINE);
  endtask

  task automatic test_random_lines(input int count);
    int               stop_at;
    int               kind;
    logic [CELLS-1:0] bits;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       bits = '1;
        1:       bits = '0;
        2, 3:    bits = last_sent_bits;
        default: bits = CELLS'($urandom_range(0, (1 << CELLS) - 1));
      endcase
      if (kind < 50) begin
        send_frame(bits, FRAME_CHARS, -1,
                   ($urandom_range(0, 1) == 0) ? 0
                     : $urandom_range(LINE_LIMIT - 1 - FRAME_CHARS - 2,
                                      LINE_LIMIT - 1 - FRAME_CHARS));
      end else if (kind < 62) begin
        send_frame(bits, FRAME_CHARS, $urandom_range(0, FRAME_CHARS - 1),
                   $urandom_range(0, 3));
      end else if (kind < 72) begin
        send_frame(bits, $urandom_range(0, FRAME_CHARS - 1), -1, 0);
      end else if (kind < 84) begin
        repeat ($urandom_range(1, 20)) send_byte(noise_byte());
        send_byte(CHAR_NEWLINE);
      end else if (kind < 92) begin
        // push to or past the line limit, either from noise or from a long frame
        if ($urandom_range(0, 1) == 0) begin
          repeat ($urandom_range(LINE_LIMIT - 1, LINE_LIMIT + 12)) send_byte(noise_byte());
          send_byte(CHAR_NEWLINE);
        end else begin
          send_frame(bits, FRAME_CHARS, -1,
                     $urandom_range(LINE_LIMIT - FRAME_CHARS, LINE_LIMIT - FRAME_CHARS + 8));
        end
      end else begin
        case ($urandom_range(0, 2))
          0:       send_byte(CHAR_RETURN);
          1:       send_byte(CHAR_NEWLINE);
          default: send_byte(noise_byte());
        endcase
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned expv,
                             input int unsigned gotv);
    if (expv != gotv) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, expv, gotv);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    byte_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with nothing pending, expected none, got state %0h",
                 $time, switch_state);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("switch_state", want.state, switch_state);
        check_field("state_valid", want.valid, state_valid);
        check_field("frame_accepted", want.accepted, frame_accepted);
        check_field("state_changed", want.changed, state_changed);
        check_field("frame_error", want.ferr, frame_error);
        check_field("line_overflow", want.ovf, line_overflow);
      end
      frames_seen    += frame_accepted;
      changes_seen   += state_changed;
      errors_seen    += frame_error;
      overflows_seen += line_overflow;
    end
  end

  initial begin : stall_pattern
    stall_mode_t mode;
    int          span;
    out_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 80);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          FREE_RUN: out_stall <= 1'b0;
          LIGHT:    out_stall <= ($urandom_range(0, 2) == 0);
          HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ((k % 5) < 2);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, pending_results.size());
    $display("[switch_frame_line_parser] ERROR");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    rx_byte        = '0;
    sender_on      = 1'b0;
    bytes_sent     = 0;
    mismatches     = 0;
    frames_seen    = 0;
    changes_seen   = 0;
    errors_seen    = 0;
    overflows_seen = 0;
    last_sent_bits = '0;
    burst_left     = $urandom_range(1, 12);
    restart_line();
    stored_bits = '0;
    have_valid  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_blank_lines();
    test_first_frame();
    test_bad_bytes();
    test_random_lines(520);

    if (sender_on) in_valid <= 1'b0;
    sender_on = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes: %0d frames taken with %0d state changes,", bytes_sent,
             frames_seen, changes_seen);
    $display("%0d bad lines and %0d overflowed lines; %0d mismatches.", errors_seen,
             overflows_seen, mismatches);
    if (mismatches == 0) begin
      $display("[switch_frame_line_parser] OK");
    end else begin
      $display("[switch_frame_line_parser] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/sfl_pkg.sv
rtl/core/switch_frame_line_parser.sv
dv/switch_frame_line_parser_tb.sv
